FILE: hdl/sha_pkg.sv
package sha_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int BLOCK_BYTES = 64;
  localparam int LEN_OFFSET  = 56;
  localparam int WORD_BYTES  = 4;
  localparam int BLOCK_WORDS = BLOCK_BYTES / WORD_BYTES;
  localparam int ROUNDS      = 64;
  localparam int HASH_WORDS  = 8;
  localparam int OUT_WORDS   = 4;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam word_t K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV_TAB [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: hdl/sha_ram.sv
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/sha256_stream_hasher.sv
// Streaming SHA-256 hasher. Each absorb item carries one message byte and is
// taken while in_stall is low; the byte that completes a 64-byte block starts
// a compression that holds in_stall high through a load step, 64 rounds at
// one round per cycle through a single round unit, and a step that folds the
// result into the chaining value. A finish item pads the message on the fly
// as block words are read, running one compression, or two when the length
// field no longer fits behind the end marker, followed by four digest items,
// most significant first, the last one flagged by out_digest_last. Input stays
// stalled until the fourth digest item is taken; the hasher then restarts from
// the initial hash values. The block buffer needs no clearing after reset.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic        out_digest_last
);
  import sha_pkg::*;

  localparam int WA_W  = $clog2(BLOCK_WORDS);
  localparam int FILL_W = $clog2(BLOCK_BYTES);
  localparam int RND_W = $clog2(ROUNDS);
  localparam int BLK_W = 64 - FILL_W - 3;

  state_t                 state_r, state_nxt;
  logic [RND_W-1:0]       rnd_r, rnd_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [BLK_W-1:0]       blocks_r, blocks_nxt;
  logic [FILL_W:0]        lim_r, lim_nxt;
  logic                   mark_r, mark_nxt;
  logic                   len_r, len_nxt;
  logic                   fin_r, fin_nxt;
  logic                   second_r, second_nxt;
  logic [1:0]             k_r, k_nxt;
  word_t                  chain_r [HASH_WORDS];
  word_t                  chain_nxt [HASH_WORDS];
  word_t                  vars_r [HASH_WORDS];
  word_t                  vars_nxt [HASH_WORDS];
  word_t                  sched_r [BLOCK_WORDS];
  word_t                  sched_nxt [BLOCK_WORDS];

  logic                   in_acc;
  logic                   out_acc;
  logic [WA_W-1:0]        rd_addr;
  logic [7:0]             ram_q [WORD_BYTES];
  logic [63:0]            total;
  word_t                  len_word;
  word_t                  blk_word;
  word_t                  w_cur;
  word_t                  t1;
  word_t                  t2;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  assign out_digest_word = {chain_r[{k_r, 1'b0}], chain_r[{k_r, 1'b1}]};
  assign out_digest_last = (k_r == 2'(OUT_WORDS - 1));

  assign rd_addr = (state_r == ST_LOAD) ? '0 : (rnd_r[WA_W-1:0] + WA_W'(1));

  for (genvar g = 0; g < WORD_BYTES; g++) begin : g_lane
    sha_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_WORDS)
    ) u_lane (
      .clk     (clk),
      .wr_en   (in_acc && (in_cmd == CMD_ABSORB) && (fill_r[1:0] == 2'(g))),
      .wr_addr (fill_r[FILL_W-1:2]),
      .wr_data (in_data_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_q[g])
    );
  end

  assign total    = {blocks_r, fill_r, 3'b000};
  assign len_word = rnd_r[0] ? total[31:0] : total[63:32];

  always_comb begin
    logic [FILL_W-1:0] idx;
    blk_word = '0;
    for (int b = 0; b < WORD_BYTES; b++) begin
      idx = {rnd_r[WA_W-1:0], 2'(b)};
      if ({1'b0, idx} < lim_r) begin
        blk_word[8*(3-b) +: 8] = ram_q[b];
      end else if (mark_r && (idx == lim_r[FILL_W-1:0])) begin
        blk_word[8*(3-b) +: 8] = PAD_MARK;
      end else if (len_r && (idx >= FILL_W'(LEN_OFFSET))) begin
        blk_word[8*(3-b) +: 8] = len_word[8*(3-b) +: 8];
      end
    end
  end

  always_comb begin
    if (rnd_r < RND_W'(BLOCK_WORDS)) begin
      w_cur = blk_word;
    end else begin
      w_cur = sched_r[0] + small_sigma0(sched_r[1]) + sched_r[9] + small_sigma1(sched_r[14]);
    end
    t1 = vars_r[7] + big_sigma1(vars_r[4])
         + ((vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]))
         + K_TAB[rnd_r] + w_cur;
    t2 = big_sigma0(vars_r[0])
         + ((vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]));
  end

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    fill_nxt   = fill_r;
    blocks_nxt = blocks_r;
    lim_nxt    = lim_r;
    mark_nxt   = mark_r;
    len_nxt    = len_r;
    fin_nxt    = fin_r;
    second_nxt = second_r;
    k_nxt      = k_r;
    chain_nxt  = chain_r;
    vars_nxt   = vars_r;
    sched_nxt  = sched_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_FINISH) begin
            fin_nxt   = 1'b1;
            lim_nxt   = {1'b0, fill_r};
            mark_nxt  = 1'b1;
            if (fill_r >= FILL_W'(LEN_OFFSET)) begin
              len_nxt    = 1'b0;
              second_nxt = 1'b1;
            end else begin
              len_nxt    = 1'b1;
              second_nxt = 1'b0;
            end
            state_nxt = ST_LOAD;
          end else if (fill_r == FILL_W'(BLOCK_BYTES - 1)) begin
            fill_nxt   = '0;
            blocks_nxt = blocks_r + BLK_W'(1);
            lim_nxt    = (FILL_W+1)'(BLOCK_BYTES);
            mark_nxt   = 1'b0;
            len_nxt    = 1'b0;
            state_nxt  = ST_LOAD;
          end else begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
      end
      ST_LOAD: begin
        rnd_nxt   = '0;
        vars_nxt  = chain_r;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          sched_nxt[i] = sched_r[i+1];
        end
        sched_nxt[BLOCK_WORDS-1] = w_cur;
        vars_nxt[7] = vars_r[6];
        vars_nxt[6] = vars_r[5];
        vars_nxt[5] = vars_r[4];
        vars_nxt[4] = vars_r[3] + t1;
        vars_nxt[3] = vars_r[2];
        vars_nxt[2] = vars_r[1];
        vars_nxt[1] = vars_r[0];
        vars_nxt[0] = t1 + t2;
        rnd_nxt = rnd_r + RND_W'(1);
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
        if (second_r) begin
          second_nxt = 1'b0;
          lim_nxt    = '0;
          mark_nxt   = 1'b0;
          len_nxt    = 1'b1;
          state_nxt  = ST_LOAD;
        end else if (fin_r) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          k_nxt = k_r + 2'd1;
          if (k_r == 2'(OUT_WORDS - 1)) begin
            chain_nxt  = IV_TAB;
            blocks_nxt = '0;
            fill_nxt   = '0;
            fin_nxt    = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      blocks_r <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      k_r      <= '0;
      chain_r  <= IV_TAB;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      blocks_r <= blocks_nxt;
      fin_r    <= fin_nxt;
      second_r <= second_nxt;
      k_r      <= k_nxt;
      chain_r  <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r   <= rnd_nxt;
    lim_r   <= lim_nxt;
    mark_r  <= mark_nxt;
    len_r   <= len_nxt;
    vars_r  <= vars_nxt;
    sched_r <= sched_nxt;
  end

`ifndef SYNTHESIS
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digest items pending");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_digest_last) |=> !out_valid)
    else $error("digest items continue past last");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ROUND) && (rnd_r == RND_W'(ROUNDS - 1))) |=> (state_r == ST_ADD))
    else $error("compression did not end after final round");

  a_finish_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_FINISH)) |=> (state_r == ST_LOAD && fin_r))
    else $error("finish item did not start padding compression");
`endif

endmodule

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 150;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic       cmd;
    logic [7:0] data;
    bit         hold;
  } msg_item_t;

  typedef struct {
    logic [63:0] word;
    logic        last;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = sha_pkg::CMD_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_word;
  logic        out_digest_last;

  msg_item_t pending_items[$];
  digest_t   expected_digests[$];

  logic [31:0] hash_st [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] bits_done;

  int err_cnt = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 1;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;
  msg_item_t nxt;
  digest_t want;

  sha256_stream_hasher i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_word(out_digest_word),
    .out_digest_last(out_digest_last)
  );

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) hash_st[i] = HASH_INIT[i];
    blk_fill = 0;
    bits_done = '0;
  endfunction

  function automatic void hash_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3))
           + (rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10));
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
    e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[t] + w[t];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endfunction

  function automatic void hash_take_byte(input logic [7:0] val);
    blk_bytes[blk_fill] = val;
    blk_fill++;
    if (blk_fill == 64) begin
      hash_compress();
      bits_done += 64'd512;
      blk_fill = 0;
    end
  endfunction

  function automatic void hash_finish();
    logic [63:0] total;
    digest_t dg;
    total = bits_done + 64'(blk_fill * 8);
    blk_bytes[blk_fill] = 8'h80;
    blk_fill++;
    // no room for the length field: flush an extra padding block
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        blk_bytes[blk_fill] = 8'h00;
        blk_fill++;
      end
      hash_compress();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin
      blk_bytes[blk_fill] = 8'h00;
      blk_fill++;
    end
    for (int k = 0; k < 8; k++) blk_bytes[56+k] = total[63-8*k -: 8];
    hash_compress();
    for (int k = 0; k < 4; k++) begin
      dg.word = {hash_st[2*k], hash_st[2*k+1]};
      dg.last = (k == 3);
      expected_digests.insert(expected_digests.size(), dg);
    end
    hash_restart();
  endfunction

  task automatic push_item(input logic cmd, input logic [7:0] data, input bit hold);
    msg_item_t it;
    it.cmd = cmd;
    it.data = data;
    it.hold = hold;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_message(input int len, input bit hold_first);
    for (int i = 0; i < len; i++)
      push_item(sha_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)), hold_first && i == 0);
    push_item(sha_pkg::CMD_FINISH, 8'($urandom_range(0, 255)), hold_first && len == 0);
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      hash_restart();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_cmd == sha_pkg::CMD_FINISH) hash_finish();
        else hash_take_byte(in_data_byte);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].hold && expected_digests.size() != 0)) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_cmd <= nxt.cmd;
          in_data_byte <= nxt.data;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 2);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= (stall_phase % 3) != 0;
        default: out_stall <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digests.size() == 0) begin
        $error("unexpected digest item: digest_word %h digest_last %b",
               out_digest_word, out_digest_last);
        err_cnt++;
      end else begin
        want = expected_digests.pop_front();
        if (out_digest_word !== want.word) begin
          $error("digest_word expected %h actual %h", want.word, out_digest_word);
          err_cnt++;
        end
        if (out_digest_last !== want.last) begin
          $error("digest_last expected %b actual %b", want.last, out_digest_last);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int len;
    // empty message, then a short one held until the digest above drains
    push_item(sha_pkg::CMD_FINISH, 8'hff, 1'b0);
    push_item(sha_pkg::CMD_ABSORB, 8'h00, 1'b1);
    push_item(sha_pkg::CMD_ABSORB, 8'hff, 1'b0);
    push_item(sha_pkg::CMD_ABSORB, 8'h61, 1'b0);
    push_item(sha_pkg::CMD_ABSORB, 8'h80, 1'b0);
    push_item(sha_pkg::CMD_FINISH, 8'h00, 1'b0);
    push_item(sha_pkg::CMD_FINISH, 8'h55, 1'b0);
    push_item(sha_pkg::CMD_ABSORB, 8'h7f, 1'b0);
    push_item(sha_pkg::CMD_ABSORB, 8'h01, 1'b0);
    push_item(sha_pkg::CMD_FINISH, 8'haa, 1'b0);
    while (pending_items.size() < 310) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 12);
        4: len = $urandom_range(55, 56);
        5: len = $urandom_range(62, 65);
        6: len = $urandom_range(118, 121);
        7: len = $urandom_range(0, 70);
        default: len = $urandom_range(1, 5);
      endcase
      add_message(len, $urandom_range(0, 3) == 0);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_valid || expected_digests.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
